// ===== rtl/ucfl_pkg.sv =====
package ucfl_pkg;

  localparam int FRAME_BYTES = 6;
  localparam int IDLE_CAP_MS = 1000;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int IDLE_W      = 10;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [IDX_W-1:0]  LAST_INDEX = IDX_W'(FRAME_BYTES - 1);
  localparam logic [IDLE_W-1:0] IDLE_CAP   = IDLE_W'(IDLE_CAP_MS);

  localparam logic [7:0]  SYNC_BYTE = 8'h55;
  localparam logic [7:0]  HEAD_BYTE = 8'hAA;
  localparam logic [7:0]  MODE_RUN  = 8'hFF;
  localparam logic [7:0]  RUN_OFF   = 8'h00;
  localparam logic [7:0]  RUN_ON    = 8'hFF;
  localparam logic [12:0] DUTY_ONE  = 13'd4096;

  localparam logic [9:0]  GAP_RESET        = 10'd50;
  localparam logic [15:0] MIN_RPM_RESET    = 16'd1000;
  localparam logic [7:0]  RPM_GAIN_RESET   = 8'd30;
  localparam logic [7:0]  SPEED_GAIN_RESET = 8'd11;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_TICK    = 2'd1,
    OP_TX_DONE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_GAP        = 2'd0,
    REG_MIN_RPM    = 2'd1,
    REG_RPM_GAIN   = 2'd2,
    REG_SPEED_GAIN = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [9:0]  gap_timeout_ms;
    logic [15:0] min_rpm;
    logic [7:0]  rpm_gain;
    logic [7:0]  speed_gain;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  value;
    logic [12:0] duty;
    logic [15:0] speed;
    logic [7:0]  run_state;
  } cmd_t;

endpackage

// ===== rtl/ucfl_cmd.sv =====
module ucfl_cmd import ucfl_pkg::*; (
  input  cfg_t       cfg,
  input  logic [7:0] mode,
  input  logic [7:0] value,
  input  logic [7:0] current_value,
  input  logic       frame_error,
  input  logic       motor_ready,
  output cmd_t       cmd
);

  logic [7:0]  value_sel;
  logic [15:0] rpm;
  logic [15:0] speed;
  logic        fast_enough;

  always_comb begin
    value_sel   = (mode == MODE_RUN) ? value : 8'd0;
    rpm         = 16'(value_sel) * 16'(cfg.rpm_gain);
    speed       = 16'(value_sel) * 16'(cfg.speed_gain);
    fast_enough = (rpm >= cfg.min_rpm);
    if (frame_error) begin
      cmd.value     = current_value;
      cmd.duty      = '0;
      cmd.speed     = '0;
      cmd.run_state = RUN_OFF;
    end else begin
      cmd.value     = value_sel;
      cmd.duty      = (fast_enough && value_sel != 8'd0) ? DUTY_ONE : '0;
      cmd.speed     = fast_enough ? speed : '0;
      cmd.run_state = motor_ready ? RUN_OFF : RUN_ON;
    end
  end

endmodule

// ===== rtl/uart_command_frame_link.sv =====
// Serial command link of a motor controller.
// Input channel (in_valid/in_ready) carries one event per request: opcode
// selects a received byte, a 1 ms tick, or a transmit-done notice, with
// rx_byte, motor_ready and alarm_flags alongside. The output channel
// (out_valid/out_ready) returns exactly one result per input request:
// tx_valid/tx_byte (reply byte to send), cmd_update/frame_bad (frame taken
// on this tick) and the current cmd_value, go_duty and cmd_speed.
// Frames are 0x55 0xAA mode value sum 0x55; the reply is
// 0x55 0xAA run_state alarm sum 0x55, one byte per tick after transmit done.
// An input register comes first, then the single-pass update that writes state
// and the result register. One request per cycle is accepted while the result
// register is empty or being taken; the rate is set by that one update stage.
// When the receiver stalls, the result register holds, and the input
// register takes one more request before in_ready drops.
// Reset (rst, synchronous) clears the frame receiver, the reply sender and
// the command, and loads gap 50 ms, min rpm 1000, rpm gain 30, speed gain 11.
// Registers sit on the APB port at 0x0, 0x4, 0x8, 0xC in that order.
module uart_command_frame_link import ucfl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [7:0]        rx_byte,
  input  logic              motor_ready,
  input  logic [7:0]        alarm_flags,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              tx_valid,
  output logic [7:0]        tx_byte,
  output logic              cmd_update,
  output logic              frame_bad,
  output logic [7:0]        cmd_value,
  output logic [12:0]       go_duty,
  output logic [15:0]       cmd_speed
);

  cfg_t cfg;

  logic       req_valid;
  logic [1:0] req_op;
  logic [7:0] req_byte;
  logic       req_ready;
  logic [7:0] req_alarm;
  logic       load;

  logic [IDX_W-1:0]  rx_index, rx_index_next;
  logic [7:0]        store1, store1_next;
  logic [7:0]        store2, store2_next;
  logic [7:0]        store3, store3_next;
  logic [7:0]        store4, store4_next;
  logic              frame_error, frame_error_next;
  logic              frame_pending, frame_pending_next;
  logic [IDLE_W-1:0] idle_ms, idle_ms_next;
  logic [IDLE_W:0]   idle_inc;
  logic              reply_trigger, reply_trigger_next;
  logic              reply_active, reply_active_next;
  logic [IDX_W-1:0]  reply_index, reply_index_next;
  logic              tx_free, tx_free_next;
  logic [7:0]        reply_mode, reply_mode_next;
  logic [7:0]        reply_alarm, reply_alarm_next;
  logic [7:0]        reply_sum, reply_sum_next;
  logic [7:0]        reply_byte;
  logic [7:0]        cmd_value_next;
  logic [12:0]       go_duty_next;
  logic [15:0]       cmd_speed_next;
  logic              tx_valid_next;
  logic [7:0]        tx_byte_next;
  logic              cmd_update_next;
  logic              frame_bad_next;
  logic              rx_bad;
  cmd_t              cmd;

  assign pready   = 1'b1;
  assign load     = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || load;

  always_comb begin
    unique case (reg_index_t'(paddr[3:2]))
      REG_GAP:        prdata = DATA_W'(cfg.gap_timeout_ms);
      REG_MIN_RPM:    prdata = DATA_W'(cfg.min_rpm);
      REG_RPM_GAIN:   prdata = DATA_W'(cfg.rpm_gain);
      REG_SPEED_GAIN: prdata = DATA_W'(cfg.speed_gain);
    endcase
  end

  ucfl_cmd u_cmd (
    .cfg           (cfg),
    .mode          (store2),
    .value         (store3),
    .current_value (cmd_value),
    .frame_error   (frame_error),
    .motor_ready   (req_ready),
    .cmd           (cmd)
  );

  always_comb begin
    unique case (reply_index)
      3'd0:    reply_byte = SYNC_BYTE;
      3'd1:    reply_byte = HEAD_BYTE;
      3'd2:    reply_byte = reply_mode;
      3'd3:    reply_byte = reply_alarm;
      3'd4:    reply_byte = reply_sum;
      default: reply_byte = SYNC_BYTE;
    endcase
  end

  always_comb begin
    rx_index_next      = rx_index;
    store1_next        = store1;
    store2_next        = store2;
    store3_next        = store3;
    store4_next        = store4;
    frame_error_next   = frame_error;
    frame_pending_next = frame_pending;
    idle_ms_next       = idle_ms;
    reply_trigger_next = reply_trigger;
    reply_active_next  = reply_active;
    reply_index_next   = reply_index;
    tx_free_next       = tx_free;
    reply_mode_next    = reply_mode;
    reply_alarm_next   = reply_alarm;
    reply_sum_next     = reply_sum;
    cmd_value_next     = cmd_value;
    go_duty_next       = go_duty;
    cmd_speed_next     = cmd_speed;
    tx_valid_next      = 1'b0;
    tx_byte_next       = 8'd0;
    cmd_update_next    = 1'b0;
    frame_bad_next     = 1'b0;
    idle_inc           = (IDLE_W + 1)'(idle_ms) + 1'b1;
    rx_bad             = (store1 != HEAD_BYTE) || (req_byte != SYNC_BYTE)
                         || (store4 != 8'(store2 + store3));

    case (opcode_t'(req_op))
      OP_RX_BYTE: begin
        idle_ms_next = '0;
        if (rx_index == '0) begin
          if (req_byte == SYNC_BYTE) begin
            rx_index_next = IDX_W'(1);
          end
        end else begin
          unique case (rx_index)
            3'd1:    store1_next = req_byte;
            3'd2:    store2_next = req_byte;
            3'd3:    store3_next = req_byte;
            3'd4:    store4_next = req_byte;
            default: ;
          endcase
          if (rx_index == LAST_INDEX) begin
            if (rx_bad) begin
              frame_error_next = 1'b1;
            end
            frame_pending_next = 1'b1;
            rx_index_next      = '0;
          end else begin
            rx_index_next = rx_index + 1'b1;
          end
        end
      end
      OP_TX_DONE: begin
        tx_free_next = 1'b1;
      end
      OP_TICK: begin
        if (!reply_active) begin
          if (reply_trigger) begin
            reply_trigger_next = 1'b0;
            reply_active_next  = 1'b1;
          end
        end else if (tx_free) begin
          tx_free_next  = 1'b0;
          tx_valid_next = 1'b1;
          tx_byte_next  = reply_byte;
          if (reply_index == LAST_INDEX) begin
            reply_active_next = 1'b0;
            reply_index_next  = '0;
          end else begin
            reply_index_next = reply_index + 1'b1;
          end
        end

        idle_ms_next = (idle_inc >= (IDLE_W + 1)'(IDLE_CAP)) ? IDLE_CAP
                                                             : idle_inc[IDLE_W-1:0];
        if (rx_index != '0 && idle_ms_next >= cfg.gap_timeout_ms) begin
          rx_index_next = '0;
        end

        if (frame_pending) begin
          frame_pending_next = 1'b0;
          frame_error_next   = 1'b0;
          cmd_update_next    = 1'b1;
          frame_bad_next     = frame_error;
          cmd_value_next     = cmd.value;
          go_duty_next       = cmd.duty;
          cmd_speed_next     = cmd.speed;
          reply_mode_next    = cmd.run_state;
          reply_alarm_next   = req_alarm;
          reply_sum_next     = 8'(cmd.run_state + req_alarm);
          reply_trigger_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_timeout_ms <= GAP_RESET;
      cfg.min_rpm        <= MIN_RPM_RESET;
      cfg.rpm_gain       <= RPM_GAIN_RESET;
      cfg.speed_gain     <= SPEED_GAIN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index_t'(paddr[3:2]))
        REG_GAP:        cfg.gap_timeout_ms <= pwdata[9:0];
        REG_MIN_RPM:    cfg.min_rpm        <= pwdata[15:0];
        REG_RPM_GAIN:   cfg.rpm_gain       <= pwdata[7:0];
        REG_SPEED_GAIN: cfg.speed_gain     <= pwdata[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op    <= opcode;
      req_byte  <= rx_byte;
      req_ready <= motor_ready;
      req_alarm <= alarm_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_valid   <= tx_valid_next;
      tx_byte    <= tx_byte_next;
      cmd_update <= cmd_update_next;
      frame_bad  <= frame_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_index      <= '0;
      store1        <= '0;
      store2        <= '0;
      store3        <= '0;
      store4        <= '0;
      frame_error   <= 1'b0;
      frame_pending <= 1'b0;
      idle_ms       <= '0;
      reply_trigger <= 1'b0;
      reply_active  <= 1'b0;
      reply_index   <= '0;
      tx_free       <= 1'b1;
      reply_mode    <= '0;
      reply_alarm   <= '0;
      reply_sum     <= '0;
      cmd_value     <= '0;
      go_duty       <= '0;
      cmd_speed     <= '0;
    end else if (load) begin
      rx_index      <= rx_index_next;
      store1        <= store1_next;
      store2        <= store2_next;
      store3        <= store3_next;
      store4        <= store4_next;
      frame_error   <= frame_error_next;
      frame_pending <= frame_pending_next;
      idle_ms       <= idle_ms_next;
      reply_trigger <= reply_trigger_next;
      reply_active  <= reply_active_next;
      reply_index   <= reply_index_next;
      tx_free       <= tx_free_next;
      reply_mode    <= reply_mode_next;
      reply_alarm   <= reply_alarm_next;
      reply_sum     <= reply_sum_next;
      cmd_value     <= cmd_value_next;
      go_duty       <= go_duty_next;
      cmd_speed     <= cmd_speed_next;
    end
  end

endmodule

// ===== rtl/ucfl_check.sv =====
module ucfl_check import ucfl_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        opcode,
  input logic [7:0]        rx_byte,
  input logic              motor_ready,
  input logic [7:0]        alarm_flags,
  input logic              out_valid,
  input logic              out_ready,
  input logic              tx_valid,
  input logic [7:0]        tx_byte,
  input logic              cmd_update,
  input logic              frame_bad,
  input logic [7:0]        cmd_value,
  input logic [12:0]       go_duty,
  input logic [15:0]       cmd_speed
);

  a_bad_needs_update: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_bad |-> cmd_update)
    else $error("frame_bad without cmd_update");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_byte == 8'd0)
    else $error("tx_byte nonzero with no reply byte");

  a_duty_levels: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> go_duty == 13'd0 || go_duty == DUTY_ONE)
    else $error("go_duty not 0 or full");

  a_duty_needs_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && go_duty != 13'd0 |-> cmd_value != 8'd0)
    else $error("run duty with stop command");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(cmd_value))
    else $error("stalled result changed");

endmodule

bind uart_command_frame_link ucfl_check u_ucfl_check (.*);

// ===== verif/testbench.sv =====
module testbench;
  import ucfl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         PHASE_ITEMS = 64;
  localparam int         HOLD_CYCLES = 120;
  localparam int         CYCLE_LIMIT = 900_000;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        cmd_update;
    logic        frame_bad;
    logic [7:0]  cmd_value;
    logic [12:0] go_duty;
    logic [15:0] cmd_speed;
  } result_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx;
    logic       ready;
    logic [7:0] alarm;
    logic       typed;
    result_t    want;
  } req_t;

  localparam result_t NO_RES    = '0;
  localparam result_t FIRST_RUN = '{1'b0, 8'h00, 1'b1, 1'b0, 8'd255, DUTY_ONE, 16'd2805};
  localparam result_t BAD_HOLD  = '{1'b1, HEAD_BYTE, 1'b1, 1'b1, 8'd255, 13'd0, 16'd0};

  localparam int DIR_ROWS = 28;
  localparam req_t DIRECTED [DIR_ROWS] = '{
    '{OP_TICK,    8'h00,     1'b1, 8'h00, 1'b1, NO_RES},
    '{OP_UNUSED,  8'hFF,     1'b1, 8'hFF, 1'b1, NO_RES},
    '{OP_TX_DONE, 8'h00,     1'b0, 8'h00, 1'b1, NO_RES},
    '{OP_RX_BYTE, 8'h00,     1'b0, 8'h00, 1'b1, NO_RES},
    '{OP_RX_BYTE, SYNC_BYTE, 1'b0, 8'h00, 1'b1, NO_RES},
    '{OP_RX_BYTE, HEAD_BYTE, 1'b0, 8'h00, 1'b1, NO_RES},
    '{OP_RX_BYTE, MODE_RUN,  1'b0, 8'h00, 1'b1, NO_RES},
    '{OP_RX_BYTE, 8'hFF,     1'b0, 8'h00, 1'b1, NO_RES},
    '{OP_RX_BYTE, 8'hFE,     1'b0, 8'h00, 1'b1, NO_RES},
    '{OP_RX_BYTE, SYNC_BYTE, 1'b0, 8'h00, 1'b1, NO_RES},
    '{OP_TICK,    8'h00,     1'b0, 8'hFF, 1'b1, FIRST_RUN},
    '{OP_TICK,    8'h00,     1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_TICK,    8'h00,     1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_TICK,    8'h00,     1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_RX_BYTE, SYNC_BYTE, 1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_RX_BYTE, HEAD_BYTE, 1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_RX_BYTE, MODE_RUN,  1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_RX_BYTE, 8'h10,     1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_RX_BYTE, 8'h00,     1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_RX_BYTE, SYNC_BYTE, 1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_TX_DONE, 8'h00,     1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_TICK,    8'h00,     1'b1, 8'h00, 1'b1, BAD_HOLD},
    '{OP_RX_BYTE, SYNC_BYTE, 1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_RX_BYTE, HEAD_BYTE, 1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_RX_BYTE, MODE_RUN,  1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_RX_BYTE, 8'h01,     1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_RX_BYTE, 8'h00,     1'b0, 8'h00, 1'b0, NO_RES},
    '{OP_RX_BYTE, SYNC_BYTE, 1'b0, 8'h80, 1'b0, NO_RES}
  };

  localparam int PHASES = 7;
  localparam cfg_t PHASE_CFG [PHASES] = '{
    '{10'd2,    16'd0,     8'd255, 8'd255},
    '{10'd0,    16'd65535, 8'd255, 8'd255},
    '{10'd1,    16'd500,   8'd0,   8'd0},
    '{10'd1023, 16'd1,     8'd1,   8'd200},
    '{10'd1000, 16'd65025, 8'd255, 8'd1},
    '{10'd3,    16'd700,   8'd30,  8'd11},
    '{10'd50,   16'd1000,  8'd30,  8'd11}
  };

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        opcode;
  logic [7:0]        rx_byte;
  logic              motor_ready;
  logic [7:0]        alarm_flags;
  logic              out_valid;
  logic              out_ready;
  logic              tx_valid;
  logic [7:0]        tx_byte;
  logic              cmd_update;
  logic              frame_bad;
  logic [7:0]        cmd_value;
  logic [12:0]       go_duty;
  logic [15:0]       cmd_speed;

  logic    row_typed;
  result_t row_want;
  logic    hold_off = 1'b0;
  int      idle_pct = 20;
  int      mismatches = 0;
  int      cycle_count = 0;

  req_t    link_events[$];
  result_t pending_results[$];

  cfg_t        link_cfg;
  logic [2:0]  rcv_pos;
  logic [7:0]  rcv_buf [FRAME_BYTES];
  logic        rcv_err;
  logic        frame_waiting;
  logic [9:0]  quiet_ms;
  logic        reply_armed;
  logic        reply_busy;
  logic [2:0]  reply_pos;
  logic        link_free;
  logic [7:0]  reply_buf [FRAME_BYTES];
  logic [7:0]  cmd_val;
  logic [12:0] duty_q12;
  logic [15:0] speed_ref;

  uart_command_frame_link u_top (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .rx_byte    (rx_byte),
    .motor_ready(motor_ready),
    .alarm_flags(alarm_flags),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tx_valid   (tx_valid),
    .tx_byte    (tx_byte),
    .cmd_update (cmd_update),
    .frame_bad  (frame_bad),
    .cmd_value  (cmd_value),
    .go_duty    (go_duty),
    .cmd_speed  (cmd_speed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void reset_link_model();
    link_cfg      = '{GAP_RESET, MIN_RPM_RESET, RPM_GAIN_RESET, SPEED_GAIN_RESET};
    rcv_pos       = '0;
    rcv_err       = 1'b0;
    frame_waiting = 1'b0;
    quiet_ms      = '0;
    reply_armed   = 1'b0;
    reply_busy    = 1'b0;
    reply_pos     = '0;
    link_free     = 1'b1;
    cmd_val       = '0;
    duty_q12      = '0;
    speed_ref     = '0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      rcv_buf[i]   = 8'h00;
      reply_buf[i] = 8'h00;
    end
    reply_buf[0] = SYNC_BYTE;
    reply_buf[1] = HEAD_BYTE;
    reply_buf[5] = SYNC_BYTE;
  endfunction

  function automatic void next_link_result(input logic [1:0] op, input logic [7:0] rx,
                                           input logic ready, input logic [7:0] alarm,
                                           output result_t res);
    logic [7:0]  sum;
    logic [15:0] rpm;
    res = '0;
    case (op)
      OP_RX_BYTE: begin
        if (rcv_pos == 0) begin
          if (rx == SYNC_BYTE) begin
            rcv_buf[0] = SYNC_BYTE;
            rcv_pos    = 3'd1;
          end
        end else begin
          rcv_buf[rcv_pos] = rx;
          rcv_pos = rcv_pos + 3'd1;
          if (rcv_pos == FRAME_BYTES) begin
            sum = rcv_buf[2] + rcv_buf[3];
            if (rcv_buf[1] != HEAD_BYTE || rcv_buf[5] != SYNC_BYTE || rcv_buf[4] != sum)
              rcv_err = 1'b1;
            frame_waiting = 1'b1;
            rcv_pos       = '0;
          end
        end
        quiet_ms = '0;
      end
      OP_TX_DONE: link_free = 1'b1;
      OP_TICK: begin
        if (!reply_busy) begin
          if (reply_armed) begin
            reply_armed = 1'b0;
            reply_busy  = 1'b1;
          end
        end else begin
          if (reply_pos < FRAME_BYTES && link_free) begin
            link_free    = 1'b0;
            res.tx_valid = 1'b1;
            res.tx_byte  = reply_buf[reply_pos];
            reply_pos    = reply_pos + 3'd1;
          end
          if (reply_pos >= FRAME_BYTES) begin
            reply_busy = 1'b0;
            reply_pos  = '0;
          end
        end
        if (quiet_ms < IDLE_CAP) quiet_ms = quiet_ms + 10'd1;
        if (rcv_pos != 0 && quiet_ms >= link_cfg.gap_timeout_ms) rcv_pos = '0;
        if (frame_waiting) begin
          frame_waiting  = 1'b0;
          res.cmd_update = 1'b1;
          if (!rcv_err) begin
            cmd_val      = (rcv_buf[2] == MODE_RUN) ? rcv_buf[3] : 8'h00;
            reply_buf[2] = ready ? RUN_OFF : RUN_ON;
            duty_q12     = (cmd_val != 0) ? DUTY_ONE : 13'd0;
            rpm          = cmd_val * link_cfg.rpm_gain;
            speed_ref    = cmd_val * link_cfg.speed_gain;
            if (rpm < link_cfg.min_rpm) begin
              duty_q12  = '0;
              speed_ref = '0;
            end
          end else begin
            rcv_err       = 1'b0;
            res.frame_bad = 1'b1;
            duty_q12      = '0;
            speed_ref     = '0;
            reply_buf[2]  = RUN_OFF;
          end
          reply_buf[3] = alarm;
          reply_buf[4] = reply_buf[2] + reply_buf[3];
          reply_armed  = 1'b1;
        end
      end
      default: ;
    endcase
    res.cmd_value = cmd_val;
    res.go_duty   = duty_q12;
    res.cmd_speed = speed_ref;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic void push_event(logic [1:0] op, logic [7:0] rx);
    req_t r;
    r       = '0;
    r.op    = op;
    r.rx    = rx;
    r.ready = 1'($urandom);
    r.alarm = 8'($urandom);
    link_events.push_back(r);
  endfunction

  function automatic void make_frame(output logic [7:0] fb [FRAME_BYTES]);
    logic [7:0] mode;
    logic [7:0] value;
    int         sel;
    mode = ($urandom_range(0, 9) < 7) ? MODE_RUN : 8'($urandom);
    sel  = $urandom_range(0, 9);
    value = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
    fb[0] = SYNC_BYTE;
    fb[1] = HEAD_BYTE;
    fb[2] = mode;
    fb[3] = value;
    fb[4] = mode + value;
    fb[5] = SYNC_BYTE;
  endfunction

  task automatic build_traffic(int n);
    int         start;
    int         pick;
    int         len;
    int         ticks;
    logic [9:0] gap;
    logic [7:0] fb [FRAME_BYTES];
    start = link_events.size();
    gap   = link_cfg.gap_timeout_ms;
    while (link_events.size() - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        make_frame(fb);
        len = FRAME_BYTES;
        if (pick >= 50) begin
          case ($urandom_range(0, 3))
            0:       fb[1] ^= 8'($urandom_range(1, 255));
            1:       fb[4] ^= 8'($urandom_range(1, 255));
            2:       fb[5] ^= 8'($urandom_range(1, 255));
            default: len = $urandom_range(1, FRAME_BYTES - 1);
          endcase
        end
        for (int i = 0; i < len; i++) push_event(OP_RX_BYTE, fb[i]);
        repeat ($urandom_range(2, 10))
          push_event(($urandom_range(0, 9) < 6) ? OP_TICK : OP_TX_DONE, 8'($urandom));
      end else if (pick < 68) begin
        repeat ($urandom_range(1, 3)) push_event(OP_RX_BYTE, 8'($urandom));
      end else if (pick < 73) begin
        make_frame(fb);
        len = $urandom_range(1, FRAME_BYTES - 1);
        for (int i = 0; i < len; i++) push_event(OP_RX_BYTE, fb[i]);
        if (gap == 0) ticks = $urandom_range(0, 2);
        else if (gap <= 60) ticks = gap - 1 + $urandom_range(0, 2);
        else ticks = $urandom_range(3, 8);
        repeat (ticks) push_event(OP_TICK, 8'($urandom));
        for (int i = len; i < FRAME_BYTES; i++) push_event(OP_RX_BYTE, fb[i]);
      end else if (pick < 97) begin
        push_event(($urandom_range(0, 9) < 6) ? OP_TICK : OP_TX_DONE, 8'($urandom));
      end else begin
        push_event(OP_UNUSED, 8'($urandom));
      end
    end
  endtask

  task automatic send_stream();
    req_t r;
    int   gap;
    while (link_events.size() != 0) begin
      r   = link_events.pop_front();
      gap = pick_gap();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid    <= 1'b1;
      opcode      <= r.op;
      rx_byte     <= r.rx;
      motor_ready <= r.ready;
      alarm_flags <= r.alarm;
      row_typed   <= r.typed;
      row_want    <= r.want;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAP:        link_cfg.gap_timeout_ms = data[9:0];
      REG_MIN_RPM:    link_cfg.min_rpm        = data[15:0];
      REG_RPM_GAIN:   link_cfg.rpm_gain       = data[7:0];
      REG_SPEED_GAIN: link_cfg.speed_gain     = data[7:0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
    mismatches++;
  endtask

  task automatic check_result(result_t got, result_t want);
    if (got.tx_valid != want.tx_valid) report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
    if (got.tx_byte != want.tx_byte) report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
    if (got.cmd_update != want.cmd_update)
      report_mismatch("cmd_update", got.cmd_update, want.cmd_update);
    if (got.frame_bad != want.frame_bad)
      report_mismatch("frame_bad", got.frame_bad, want.frame_bad);
    if (got.cmd_value != want.cmd_value)
      report_mismatch("cmd_value", got.cmd_value, want.cmd_value);
    if (got.go_duty != want.go_duty) report_mismatch("go_duty", got.go_duty, want.go_duty);
    if (got.cmd_speed != want.cmd_speed)
      report_mismatch("cmd_speed", got.cmd_speed, want.cmd_speed);
  endtask

  always @(posedge clk) begin : accept_request
    result_t predicted;
    if (!rst && in_valid && in_ready) begin
      next_link_result(opcode, rx_byte, motor_ready, alarm_flags, predicted);
      pending_results.push_back(row_typed ? row_want : predicted);
    end
  end

  always @(posedge clk) begin : check_response
    result_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{tx_valid, tx_byte, cmd_update, frame_bad, cmd_value, go_duty, cmd_speed};
      if (pending_results.size() == 0) report_mismatch("result with no request", 1, 0);
      else check_result(got, pending_results.pop_front());
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : drive_out_ready
    int gap;
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : run_test
    cfg_t c;
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    opcode      <= OP_RX_BYTE;
    rx_byte     <= 8'h00;
    motor_ready <= 1'b0;
    alarm_flags <= 8'h00;
    row_typed   <= 1'b0;
    row_want    <= NO_RES;
    reset_link_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) link_events.push_back(DIRECTED[i]);
    send_stream();

    for (int p = 0; p <= PHASES; p++) begin
      wait_drained();
      if (p > 0) begin
        c = PHASE_CFG[p-1];
        write_reg(REG_GAP, DATA_W'(c.gap_timeout_ms));
        write_reg(REG_MIN_RPM, DATA_W'(c.min_rpm));
        write_reg(REG_RPM_GAIN, DATA_W'(c.rpm_gain));
        write_reg(REG_SPEED_GAIN, DATA_W'(c.speed_gain));
      end
      idle_pct = (p == 1) ? 0 : 25;
      build_traffic(PHASE_ITEMS);
      if (link_cfg.gap_timeout_ms > IDLE_CAP) begin
        push_event(OP_RX_BYTE, SYNC_BYTE);
        push_event(OP_RX_BYTE, HEAD_BYTE);
        push_event(OP_RX_BYTE, MODE_RUN);
        repeat (IDLE_CAP_MS + 10) push_event(OP_TICK, 8'($urandom));
        push_event(OP_RX_BYTE, 8'h40);
        push_event(OP_RX_BYTE, 8'h3F);
        push_event(OP_RX_BYTE, SYNC_BYTE);
        push_event(OP_TICK, 8'($urandom));
      end
      if (p == 2) hold_off = 1'b1;
      send_stream();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
